// ===== rtl/core/wsfd_pkg.sv =====
// Shared types, constants and codes for the weather sensor frame decoder.
`default_nettype none
package wsfd_pkg;

   localparam logic [3:0] MAX_QUARTETS = 4'd15;
   localparam logic [7:0] CRC_POLY     = 8'h31;
   localparam logic [3:0] START_NIBBLE = 4'hA;
   localparam logic [3:0] ID_MASK      = 4'hC;
   localparam logic [11:0] TEMP_OFFSET = 12'd400;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_CRC   = 2'd1;
   localparam logic [1:0] STATUS_START = 2'd2;

   localparam logic [3:0] QTYPE_TEMP  = 4'd0;
   localparam logic [3:0] QTYPE_HUMID = 4'd1;
   localparam logic [3:0] QTYPE_RAIN  = 4'd2;
   localparam logic [3:0] QTYPE_WIND  = 4'd3;
   localparam logic [3:0] QTYPE_GUST  = 4'd4;

   localparam int FLAG_TEMP  = 0;
   localparam int FLAG_HUMID = 1;
   localparam int FLAG_RAIN  = 2;
   localparam int FLAG_WIND  = 3;
   localparam int FLAG_GUST  = 4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [7:0]         sensor_id;
      logic               error_bit;
      logic [5:0]         frame_length;
      logic [4:0]         data_flags;
      logic signed [11:0] temp_tenths_c;
      logic [7:0]         humidity;
      logic [3:0]         wind_dir_index;
      logic [7:0]         wind_speed_tenths;
      logic [11:0]        gust_speed;
   } rsp_type;

   typedef struct packed {
      logic [11:0] temp;
      logic [7:0]  humidity;
      logic [3:0]  wind_dir;
      logic [7:0]  wind_speed;
      logic [11:0] gust;
   } values_type;

endpackage
`default_nettype wire

// ===== rtl/core/wsfd_in_reg.sv =====
// Input register for received frame bytes.
`default_nettype none
module wsfd_in_reg (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire wsfd_pkg::req_type req_data,
   input  wire logic             take,
   output logic                  item_valid,
   output wsfd_pkg::req_type     item_data
);
   import wsfd_pkg::*;

   logic    valid_ff, valid_in;
   req_type data_ff, data_in;
   logic    accept;

   assign req_stall = valid_ff && !take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (accept) begin
         valid_in = 1'b1;
         data_in  = req_data;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;
endmodule
`default_nettype wire

// ===== rtl/core/wsfd_quartet_decode.sv =====
// Decode of one completed quartet into pending flags and values.
`default_nettype none
module wsfd_quartet_decode (
   input  wire logic [7:0]           first_byte,
   input  wire logic [7:0]           second_byte,
   input  wire logic                 error_bit,
   input  wire logic [4:0]           flags_cur,
   input  wire wsfd_pkg::values_type values_cur,
   output logic [4:0]                flags_new,
   output wsfd_pkg::values_type      values_new
);
   import wsfd_pkg::*;

   logic [3:0]  qtype, q1, q2, q3;
   logic [10:0] bcd;

   assign qtype = first_byte[7:4];
   assign q1    = first_byte[3:0];
   assign q2    = second_byte[7:4];
   assign q3    = second_byte[3:0];
   assign bcd   = 11'(q1) * 11'd100 + 11'(q2) * 11'd10 + 11'(q3);

   always_comb begin
      flags_new  = flags_cur;
      values_new = values_cur;
      case (qtype)
         QTYPE_TEMP: begin
            values_new.temp       = 12'(bcd) - TEMP_OFFSET;
            flags_new[FLAG_TEMP]  = 1'b1;
         end
         QTYPE_HUMID: begin
            values_new.humidity   = bcd[7:0];
            flags_new[FLAG_HUMID] = 1'b1;
         end
         QTYPE_RAIN: begin
            flags_new[FLAG_RAIN]  = 1'b1;
         end
         QTYPE_WIND: begin
            if (!error_bit) begin
               values_new.wind_dir   = q1;
               values_new.wind_speed = {q2, q3};
               flags_new[FLAG_WIND]  = 1'b1;
            end
         end
         QTYPE_GUST: begin
            values_new.gust       = {q1, 4'h0, q2};
            flags_new[FLAG_GUST]  = 1'b1;
         end
         default: begin
         end
      endcase
   end
endmodule
`default_nettype wire

// ===== rtl/core/wsfd_parser.sv =====
// Frame parser: byte position, running CRC, header fields and result build.
`default_nettype none
module wsfd_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire wsfd_pkg::req_type item_data,
   output logic                   result_load,
   output wsfd_pkg::rsp_type      result_data
);
   import wsfd_pkg::*;

   function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   logic [5:0] idx_ff, idx_in;
   logic [5:0] len_ff, len_in;
   logic [7:0] crc_ff, crc_in;
   logic       start_ok_ff, start_ok_in;
   logic [7:0] id_ff, id_in;
   logic       err_ff, err_in;
   logic [7:0] first_ff, first_in;
   logic [4:0] flags_ff, flags_in;
   values_type values_ff, values_in;

   logic [4:0] dec_flags;
   values_type dec_values;
   logic [7:0] b;
   logic [3:0] q_sat;
   logic [1:0] status;
   logic       ok;

   assign b     = item_data.data_byte;
   assign q_sat = (b[3:0] > MAX_QUARTETS) ? MAX_QUARTETS : b[3:0];

   wsfd_quartet_decode u_decode (
      .first_byte  (first_ff),
      .second_byte (b),
      .error_bit   (err_ff),
      .flags_cur   (flags_ff),
      .values_cur  (values_ff),
      .flags_new   (dec_flags),
      .values_new  (dec_values)
   );

   always_comb begin
      if (crc_ff != b) begin
         status = STATUS_CRC;
      end else if (!start_ok_ff) begin
         status = STATUS_START;
      end else begin
         status = STATUS_OK;
      end
      ok = (status == STATUS_OK);
      result_data.status            = status;
      result_data.sensor_id         = id_ff;
      result_data.error_bit         = err_ff;
      result_data.frame_length      = len_ff;
      result_data.data_flags        = ok ? flags_ff : 5'd0;
      result_data.temp_tenths_c     = ok ? values_ff.temp : 12'd0;
      result_data.humidity          = ok ? values_ff.humidity : 8'd0;
      result_data.wind_dir_index    = ok ? values_ff.wind_dir : 4'd0;
      result_data.wind_speed_tenths = ok ? values_ff.wind_speed : 8'd0;
      result_data.gust_speed        = ok ? values_ff.gust : 12'd0;
   end

   always_comb begin
      idx_in      = idx_ff;
      len_in      = len_ff;
      crc_in      = crc_ff;
      start_ok_in = start_ok_ff;
      id_in       = id_ff;
      err_in      = err_ff;
      first_in    = first_ff;
      flags_in    = flags_ff;
      values_in   = values_ff;
      result_load = 1'b0;
      if (fire) begin
         if (item_data.frame_start) begin
            start_ok_in = (b[7:4] == START_NIBBLE);
            id_in       = {b[3:0], 4'h0};
            err_in      = 1'b0;
            crc_in      = crc_byte(8'h00, b);
            len_in      = 6'd0;
            first_in    = 8'h00;
            flags_in    = 5'd0;
            values_in   = '0;
            idx_in      = 6'd1;
         end else if (idx_ff == 6'd1) begin
            id_in  = {id_ff[7:4], b[7:4] & ID_MASK};
            err_in = b[4];
            len_in = {1'b0, q_sat, 1'b0} + 6'd3;
            crc_in = crc_byte(crc_ff, b);
            idx_in = 6'd2;
         end else if (idx_ff != 6'd0) begin
            if (({1'b0, idx_ff} + 7'd1) < {1'b0, len_ff}) begin
               crc_in = crc_byte(crc_ff, b);
               if (!idx_ff[0]) begin
                  first_in = b;
               end else begin
                  flags_in  = dec_flags;
                  values_in = dec_values;
               end
               idx_in = idx_ff + 6'd1;
            end else begin
               result_load = 1'b1;
               idx_in      = 6'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 6'd0;
      end else begin
         idx_ff <= idx_in;
      end
      len_ff      <= len_in;
      crc_ff      <= crc_in;
      start_ok_ff <= start_ok_in;
      id_ff       <= id_in;
      err_ff      <= err_in;
      first_ff    <= first_in;
      flags_ff    <= flags_in;
      values_ff   <= values_in;
   end
endmodule
`default_nettype wire

// ===== rtl/core/wsfd_out_reg.sv =====
// Result register toward the response channel.
`default_nettype none
module wsfd_out_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire wsfd_pkg::rsp_type load_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output wsfd_pkg::rsp_type      rsp_data
);
   import wsfd_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;
endmodule
`default_nettype wire

// ===== rtl/core/weather_sensor_frame_decoder.sv =====
// Top level of the weather sensor frame decoder.
//
//  Channel  Prefix  Direction  Payload    Transfer
//  request  req_    in         req_type   one frame byte
//  result   rsp_    out        rsp_type   one decoded frame, on its CRC byte
//
// A byte is held in the input register, then is parsed and, on the
// CRC byte, the result is loaded into the output register. One byte per
// cycle is sustained while the output is not stalled. Reset clears the
// byte position and both valid bits. Input is stalled only while the input
// register is full and a result waits, stalled, in the output register.
`default_nettype none
module weather_sensor_frame_decoder (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire wsfd_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output wsfd_pkg::rsp_type      rsp_data
);
   import wsfd_pkg::*;

   logic    take;
   logic    item_valid;
   req_type item_data;
   logic    result_load;
   rsp_type result_data;

   assign take = item_valid && (!rsp_valid || !rsp_stall);

   wsfd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .take       (take),
      .item_valid (item_valid),
      .item_data  (item_data)
   );

   wsfd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .fire        (take),
      .item_data   (item_data),
      .result_load (result_load),
      .result_data (result_data)
   );

   wsfd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (result_load),
      .load_data (result_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_stall_only_when_blocked : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while result path free");

   a_bad_frame_no_data : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STATUS_OK) |-> (rsp_data.data_flags == 5'd0))
      else $error("rejected frame carries data flags");

   a_length_odd : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.frame_length[0] && rsp_data.frame_length >= 6'd3))
      else $error("frame length not a valid quartet length");

   a_wind_needs_no_error : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.error_bit) |-> !rsp_data.data_flags[FLAG_WIND])
      else $error("wind reported with error bit set");
endmodule
`default_nettype wire
